// ----- rtl/frs_pkg.sv -----
// ----------------------------------------------------------------------------
// frs_pkg
// Shared widths, register indexes, mode codes and pixel helpers for the
// NV12 frame store and RGB565 scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package frs_pkg;

	localparam int SOURCE_SIDE_DEF = 128;

	localparam int DIM_W   = 13;
	localparam int COORD_W = 12;
	localparam int OFS_W   = 12;
	localparam int ADDR_W  = 15;
	localparam int BYTE_W  = 8;
	localparam int PIX_W   = 16;
	localparam int MODE_W  = 2;
	localparam int IDX_W   = 2;

	localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_MODE   = 2'd2;

	localparam logic [MODE_W-1:0] MODE_COLOUR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GRAY   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FLOW   = 2'd2;

	localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd128;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd128;

	localparam logic [BYTE_W-1:0] FLOW_CODE_BLACK   = 8'd0;
	localparam logic [BYTE_W-1:0] FLOW_CODE_RED     = 8'd50;
	localparam logic [BYTE_W-1:0] FLOW_CODE_CYAN    = 8'd100;
	localparam logic [BYTE_W-1:0] FLOW_CODE_GREEN   = 8'd150;
	localparam logic [BYTE_W-1:0] FLOW_CODE_MAGENTA = 8'd200;

	localparam logic [PIX_W-1:0] PIX_BLACK   = 16'h0000;
	localparam logic [PIX_W-1:0] PIX_RED     = 16'hf800;
	localparam logic [PIX_W-1:0] PIX_CYAN    = 16'h07ff;
	localparam logic [PIX_W-1:0] PIX_GREEN   = 16'h07e0;
	localparam logic [PIX_W-1:0] PIX_MAGENTA = 16'hf81f;

	// BT.601-style coefficients, scaled by 256
	localparam logic signed [10:0] COEF_RV = 11'sd359;
	localparam logic signed [10:0] COEF_GU = 11'sd88;
	localparam logic signed [10:0] COEF_GV = 11'sd183;
	localparam logic signed [10:0] COEF_BU = 11'sd454;

	typedef struct packed {
		logic [DIM_W-1:0]  side;
		logic [OFS_W-1:0]  x0;
		logic [OFS_W-1:0]  y0;
		logic [MODE_W-1:0] mode;
	} geom_t;

	function automatic logic [PIX_W-1:0] pack565(input logic [BYTE_W-1:0] r,
		input logic [BYTE_W-1:0] g, input logic [BYTE_W-1:0] b);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

	function automatic logic [BYTE_W-1:0] clamp8(input logic signed [11:0] a);
		logic [BYTE_W-1:0] res;
		if (a < 12'sd0) begin
			res = 8'd0;
		end else if (a > 12'sd255) begin
			res = 8'd255;
		end else begin
			res = a[7:0];
		end
		return res;
	endfunction

	function automatic logic [PIX_W-1:0] flow565(input logic [BYTE_W-1:0] code);
		logic [PIX_W-1:0] res;
		unique case (code)
			FLOW_CODE_BLACK:   res = PIX_BLACK;
			FLOW_CODE_RED:     res = PIX_RED;
			FLOW_CODE_CYAN:    res = PIX_CYAN;
			FLOW_CODE_GREEN:   res = PIX_GREEN;
			FLOW_CODE_MAGENTA: res = PIX_MAGENTA;
			default:           res = pack565(code, code, code);
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/frs_ram.sv -----
// ----------------------------------------------------------------------------
// frs_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module frs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/frs_cfg.sv -----
// ----------------------------------------------------------------------------
// frs_cfg
// Display registers, centred-square geometry and a bit-serial restoring
// divider for the source-to-square side ratio, 8.16 at the default side.
// ----------------------------------------------------------------------------
`default_nettype none

module frs_cfg #(
	parameter int SOURCE_SIDE = frs_pkg::SOURCE_SIDE_DEF,
	parameter int INV_W       = $clog2(SOURCE_SIDE) + 17
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [frs_pkg::IDX_W-1:0]  cfg_index,
	input  logic [frs_pkg::DIM_W-1:0]  cfg_data,
	output frs_pkg::geom_t             geom,
	output logic [INV_W-1:0]           inv,
	output logic                       busy
);

	import frs_pkg::*;

	localparam int CNT_W = $clog2(INV_W);
	localparam logic [INV_W-1:0] NUM = INV_W'(SOURCE_SIDE * 65536);

	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [MODE_W-1:0] mode_q;
	logic [DIM_W-1:0]  side_c;
	logic              restart;
	logic              run_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIM_W-1:0]  rem_q;
	logic [INV_W-1:0]  quo_q;
	logic [DIM_W:0]    rem_sh;
	logic [DIM_W:0]    rem_sub;
	logic              fit;
	geom_t             geom_q;

	assign side_c  = (width_q < height_q) ? width_q : height_q;
	assign restart = cfg_we && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));
	assign rem_sh  = {rem_q, quo_q[INV_W-1]};
	assign fit     = rem_sh >= {1'b0, side_c};
	assign rem_sub = rem_sh - {1'b0, side_c};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			mode_q   <= MODE_COLOUR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_MODE:   mode_q   <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// divider runs after reset and after any width or height write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b1;
			cnt_q <= '0;
			rem_q <= '0;
			quo_q <= NUM;
		end else if (restart) begin
			run_q <= 1'b1;
			cnt_q <= '0;
			rem_q <= '0;
			quo_q <= NUM;
		end else if (run_q) begin
			if (cnt_q == CNT_W'(INV_W - 1)) begin
				run_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
			rem_q <= fit ? rem_sub[DIM_W-1:0] : rem_sh[DIM_W-1:0];
			quo_q <= {quo_q[INV_W-2:0], fit};
		end
	end

	always_ff @(posedge clk) begin
		geom_q.side <= side_c;
		geom_q.x0   <= OFS_W'((width_q - side_c) >> 1);
		geom_q.y0   <= OFS_W'((height_q - side_c) >> 1);
		geom_q.mode <= mode_q;
	end

	assign geom = geom_q;
	assign inv  = quo_q;
	assign busy = run_q;

endmodule

`default_nettype wire

// ----- rtl/frs_conv.sv -----
// ----------------------------------------------------------------------------
// frs_conv
// YUV to RGB565 conversion: coefficient products in one stage, then
// clamping, packing and mode selection.
// ----------------------------------------------------------------------------
`default_nettype none

module frs_conv (
	input  logic                        clk,
	input  logic                        load,
	input  logic [frs_pkg::BYTE_W-1:0]  luma,
	input  logic [frs_pkg::BYTE_W-1:0]  cb,
	input  logic [frs_pkg::BYTE_W-1:0]  cr,
	input  logic [frs_pkg::MODE_W-1:0]  mode,
	output logic [frs_pkg::PIX_W-1:0]   pix
);

	import frs_pkg::*;

	logic signed [8:0]  u_c;
	logic signed [8:0]  v_c;
	logic signed [19:0] r_prod;
	logic signed [19:0] g_prod;
	logic signed [19:0] b_prod;

	logic [BYTE_W-1:0]  y_s1;
	logic [MODE_W-1:0]  mode_s1;
	logic signed [11:0] rt_s1;
	logic signed [11:0] gt_s1;
	logic signed [11:0] bt_s1;

	logic signed [11:0] y_ext;
	logic signed [11:0] r_sum;
	logic signed [11:0] g_sum;
	logic signed [11:0] b_sum;

	assign u_c    = $signed({1'b0, cb}) - 9'sd128;
	assign v_c    = $signed({1'b0, cr}) - 9'sd128;
	assign r_prod = COEF_RV * v_c;
	assign g_prod = COEF_GU * u_c + COEF_GV * v_c;
	assign b_prod = COEF_BU * u_c;

	// upper bits of the product are the floor of product / 256
	always_ff @(posedge clk) begin
		if (load) begin
			y_s1    <= luma;
			mode_s1 <= mode;
			rt_s1   <= r_prod[19:8];
			gt_s1   <= g_prod[19:8];
			bt_s1   <= b_prod[19:8];
		end
	end

	assign y_ext = $signed({4'b0000, y_s1});
	assign r_sum = y_ext + rt_s1;
	assign g_sum = y_ext - gt_s1;
	assign b_sum = y_ext + bt_s1;

	always_comb begin
		unique case (mode_s1)
			MODE_GRAY: pix = pack565(y_s1, y_s1, y_s1);
			MODE_FLOW: pix = flow565(y_s1);
			default:   pix = pack565(clamp8(r_sum), clamp8(g_sum), clamp8(b_sum));
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/frame_to_rgb565_scaler.sv -----
// ----------------------------------------------------------------------------
// frame_to_rgb565_scaler
// NV12 source frame store with a nearest-neighbour RGB565 display read port.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A byte write keeps
// busy high through the write state. A pixel read returns its result on
// pixel_rgb565 with done high for one cycle; done cannot be held off, so
// the result must be taken in that cycle. Reads go through a fixed
// sequencer: offset, scaling multiply, address forming, one luma and two
// chroma reads on the single read port of each frame memory, then
// conversion. After reset and after every write to the width or height
// register busy stays high while the ratio divider runs, one quotient bit
// per cycle. Memory contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_to_rgb565_scaler #(
	parameter int SOURCE_SIDE = frs_pkg::SOURCE_SIDE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [frs_pkg::IDX_W-1:0]    cfg_index,
	input  logic [frs_pkg::DIM_W-1:0]    cfg_data,
	input  logic                         start,
	output logic                         busy,
	input  logic                         req_type,
	input  logic [frs_pkg::ADDR_W-1:0]   byte_address,
	input  logic [frs_pkg::BYTE_W-1:0]   byte_value,
	input  logic [frs_pkg::COORD_W-1:0]  pixel_x,
	input  logic [frs_pkg::COORD_W-1:0]  pixel_y,
	output logic                         done,
	output logic [frs_pkg::PIX_W-1:0]    pixel_rgb565
);

	import frs_pkg::*;

	localparam int INV_W     = $clog2(SOURCE_SIDE) + 17;
	localparam int LUMA_N    = SOURCE_SIDE * SOURCE_SIDE;
	localparam int CHROMA_N  = LUMA_N / 2;
	localparam int LUMA_AW   = $clog2(LUMA_N);
	localparam int CHROMA_AW = $clog2(CHROMA_N);
	localparam int SRC_W     = $clog2(SOURCE_SIDE);
	localparam int SPAN_W    = $clog2(LUMA_N + CHROMA_N);
	localparam int WA_W      = ((SPAN_W > ADDR_W) ? SPAN_W : ADDR_W) + 1;
	localparam int PROD_W    = OFS_W + INV_W;
	localparam int SHF_W     = PROD_W - 16;
	localparam int CB_W      = LUMA_AW + 1;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_WRITE = 4'd1;
	localparam logic [3:0] ST_OFFS  = 4'd2;
	localparam logic [3:0] ST_MUL   = 4'd3;
	localparam logic [3:0] ST_ADDR  = 4'd4;
	localparam logic [3:0] ST_RD1   = 4'd5;
	localparam logic [3:0] ST_RD2   = 4'd6;
	localparam logic [3:0] ST_CONV  = 4'd7;
	localparam logic [3:0] ST_FIN   = 4'd8;

	geom_t              geom;
	logic [INV_W-1:0]   inv;
	logic               cfg_busy;

	logic [3:0]         state_q;
	logic [3:0]         state_d;
	logic               accept;

	logic [ADDR_W-1:0]  addr_q;
	logic [BYTE_W-1:0]  val_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;

	logic [DIM_W-1:0]   dx_c;
	logic [DIM_W-1:0]   dy_c;
	logic               inside_c;
	logic               inside_q;
	logic [OFS_W-1:0]   ox_q;
	logic [OFS_W-1:0]   oy_q;
	logic [PROD_W-1:0]  prod_x_q;
	logic [PROD_W-1:0]  prod_y_q;

	logic [SHF_W-1:0]   shx_c;
	logic [SHF_W-1:0]   shy_c;
	logic [SRC_W-1:0]   sx_c;
	logic [SRC_W-1:0]   sy_c;
	logic [CB_W-1:0]    luma_idx_c;
	logic [CB_W-1:0]    cbase_c;
	logic [CB_W-1:0]    cnext_c;
	logic [CB_W-1:0]    cu_c;
	logic [CB_W-1:0]    cv_c;
	logic [LUMA_AW-1:0]   la_q;
	logic [CHROMA_AW-1:0] cu_q;
	logic [CHROMA_AW-1:0] cv_q;

	logic [WA_W-1:0]    wa_c;
	logic [WA_W-1:0]    ca_c;
	logic               luma_we;
	logic               chroma_we;
	logic [CHROMA_AW-1:0] chroma_raddr;
	logic [BYTE_W-1:0]  luma_rd;
	logic [BYTE_W-1:0]  chroma_rd;
	logic [BYTE_W-1:0]  luma_q;
	logic [BYTE_W-1:0]  cb_q;
	logic [PIX_W-1:0]   conv_pix;

	logic               done_q;
	logic [PIX_W-1:0]   pix_q;

	frs_cfg #(
		.SOURCE_SIDE (SOURCE_SIDE),
		.INV_W       (INV_W)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom),
		.inv       (inv),
		.busy      (cfg_busy)
	);

	assign busy   = (state_q != ST_IDLE) || cfg_busy;
	assign accept = start && !busy;

	always_comb begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = req_type ? ST_OFFS : ST_WRITE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_WRITE: state_d = ST_IDLE;
			ST_OFFS:  state_d = ST_MUL;
			ST_MUL:   state_d = ST_ADDR;
			ST_ADDR:  state_d = ST_RD1;
			ST_RD1:   state_d = ST_RD2;
			ST_RD2:   state_d = ST_CONV;
			ST_CONV:  state_d = ST_FIN;
			ST_FIN:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_FIN);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= byte_address;
			val_q  <= byte_value;
			x_q    <= pixel_x;
			y_q    <= pixel_y;
		end
	end

	// centred square test and offsets into it
	assign dx_c     = {1'b0, x_q} - {1'b0, geom.x0};
	assign dy_c     = {1'b0, y_q} - {1'b0, geom.y0};
	assign inside_c = (x_q >= geom.x0) && (dx_c < geom.side) &&
	                  (y_q >= geom.y0) && (dy_c < geom.side);

	always_ff @(posedge clk) begin
		if (state_q == ST_OFFS) begin
			inside_q <= inside_c;
			ox_q     <= dx_c[OFS_W-1:0];
			oy_q     <= dy_c[OFS_W-1:0];
		end
		if (state_q == ST_MUL) begin
			prod_x_q <= PROD_W'(ox_q) * PROD_W'(inv);
			prod_y_q <= PROD_W'(oy_q) * PROD_W'(inv);
		end
	end

	// source index with clamp, then luma and chroma pair addresses
	assign shx_c = prod_x_q[PROD_W-1:16];
	assign shy_c = prod_y_q[PROD_W-1:16];
	assign sx_c  = (shx_c > SHF_W'(SOURCE_SIDE - 1)) ? SRC_W'(SOURCE_SIDE - 1)
	                                                  : shx_c[SRC_W-1:0];
	assign sy_c  = (shy_c > SHF_W'(SOURCE_SIDE - 1)) ? SRC_W'(SOURCE_SIDE - 1)
	                                                  : shy_c[SRC_W-1:0];

	assign luma_idx_c = CB_W'(sy_c) * CB_W'(SOURCE_SIDE) + CB_W'(sx_c);
	assign cbase_c    = CB_W'(sy_c >> 1) * CB_W'(SOURCE_SIDE) +
	                    CB_W'({sx_c[SRC_W-1:1], 1'b0});
	assign cnext_c    = cbase_c + 1'b1;
	assign cu_c = (cbase_c >= CB_W'(CHROMA_N)) ? cbase_c - CB_W'(CHROMA_N) : cbase_c;
	assign cv_c = (cnext_c >= CB_W'(CHROMA_N)) ? cnext_c - CB_W'(CHROMA_N) : cnext_c;

	always_ff @(posedge clk) begin
		if (state_q == ST_ADDR) begin
			la_q <= luma_idx_c[LUMA_AW-1:0];
			cu_q <= cu_c[CHROMA_AW-1:0];
			cv_q <= cv_c[CHROMA_AW-1:0];
		end
		if (state_q == ST_RD2) begin
			luma_q <= luma_rd;
			cb_q   <= chroma_rd;
		end
	end

	// write decode: luma plane first, then interleaved chroma
	assign wa_c      = WA_W'(addr_q);
	assign ca_c      = wa_c - WA_W'(LUMA_N);
	assign luma_we   = (state_q == ST_WRITE) && (wa_c < WA_W'(LUMA_N));
	assign chroma_we = (state_q == ST_WRITE) && (wa_c >= WA_W'(LUMA_N)) &&
	                   (ca_c < WA_W'(CHROMA_N));

	assign chroma_raddr = (state_q == ST_RD2) ? cv_q : cu_q;

	frs_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (LUMA_N)
	) u_luma_ram (
		.clk   (clk),
		.we    (luma_we),
		.waddr (wa_c[LUMA_AW-1:0]),
		.wdata (val_q),
		.raddr (la_q),
		.rdata (luma_rd)
	);

	frs_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (CHROMA_N)
	) u_chroma_ram (
		.clk   (clk),
		.we    (chroma_we),
		.waddr (ca_c[CHROMA_AW-1:0]),
		.wdata (val_q),
		.raddr (chroma_raddr),
		.rdata (chroma_rd)
	);

	frs_conv u_conv (
		.clk  (clk),
		.load (state_q == ST_CONV),
		.luma (luma_q),
		.cb   (cb_q),
		.cr   (chroma_rd),
		.mode (geom.mode),
		.pix  (conv_pix)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN) begin
			pix_q <= inside_q ? conv_pix : PIX_BLACK;
		end
	end

	assign done         = done_q;
	assign pixel_rgb565 = pix_q;

endmodule

`default_nettype wire

// ----- rtl/frs_checker.sv -----
// ----------------------------------------------------------------------------
// frs_checker
// Port-level timing checks for the scaler: read latency, write items give
// no result, single-cycle result strobe, busy after every accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

module frs_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic req_type,
	input logic done
);

	logic accept;

	assign accept = start && !busy;

	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req_type |-> ##8 done)
		else $error("read item gave no result at the expected cycle");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !req_type |-> ##8 !done)
		else $error("write item produced a result");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy low in the cycle after an accepted item");

endmodule

bind frame_to_rgb565_scaler frs_checker u_frs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.req_type (req_type),
	.done     (done)
);

`default_nettype wire

// ----- dv/frame_to_rgb565_scaler_tb.sv -----
// ----------------------------------------------------------------------------
// frame_to_rgb565_scaler_tb
// Self-checking bench for the NV12 frame store and RGB565 scaler. A queue
// of byte writes and pixel reads feeds a start/busy driver. A monitor
// compares each done strobe with a pixel worked out by a local model of the
// frame store, the centred square and the colour modes. The run covers a
// short directed set and random phases under several display sizes and
// modes; source bytes a read depends on are written ahead of that read.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module frame_to_rgb565_scaler_tb;

	import frs_pkg::*;

	localparam int SIDE         = SOURCE_SIDE_DEF;
	localparam int LUMA_BYTES   = SIDE * SIDE;
	localparam int CHROMA_BYTES = LUMA_BYTES / 2;
	localparam int PHASE_ITEMS  = 92;
	localparam int SETTLE_CYCLES = 16;
	localparam int IDLE_LIMIT   = 2000;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	typedef struct {
		logic               kind;
		logic [ADDR_W-1:0]  addr;
		logic [BYTE_W-1:0]  value;
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
	} frame_cmd_t;

	typedef struct {
		logic [PIX_W-1:0]   pix;
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
	} pixel_exp_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [IDX_W-1:0]    cfg_index = REG_WIDTH;
	logic [DIM_W-1:0]    cfg_data = '0;
	logic                start = 1'b0;
	logic                busy;
	logic                req_type = REQ_WRITE;
	logic [ADDR_W-1:0]   byte_address = '0;
	logic [BYTE_W-1:0]   byte_value = '0;
	logic [COORD_W-1:0]  pixel_x = '0;
	logic [COORD_W-1:0]  pixel_y = '0;
	logic                done;
	logic [PIX_W-1:0]    pixel_rgb565;

	// local copy of frame and registers
	logic [BYTE_W-1:0] luma_img [0:LUMA_BYTES-1];
	logic [BYTE_W-1:0] chroma_img [0:CHROMA_BYTES-1];
	// entries already queued for writing
	bit                luma_set [0:LUMA_BYTES-1];
	bit                chroma_set [0:CHROMA_BYTES-1];
	logic [DIM_W-1:0]  disp_w = WIDTH_RST;
	logic [DIM_W-1:0]  disp_h = HEIGHT_RST;
	logic [MODE_W-1:0] col_mode = MODE_COLOUR;

	frame_cmd_t frame_cmds [$];
	pixel_exp_t pending_pixels [$];
	frame_cmd_t cur;
	pixel_exp_t want;
	pixel_exp_t seen;

	int unsigned gap_left = 0;
	int unsigned burst_left = 0;
	int unsigned roll;
	int unsigned idle_cycles = 0;
	int unsigned n_pushed = 0;
	int unsigned n_writes = 0;
	int unsigned n_ignored = 0;
	int unsigned n_reads = 0;
	int unsigned n_checked = 0;
	int unsigned n_errors = 0;
	int unsigned n_settings = 1;

	logic [BYTE_W-1:0] flow_codes [0:4] = '{FLOW_CODE_BLACK, FLOW_CODE_RED,
		FLOW_CODE_CYAN, FLOW_CODE_GREEN, FLOW_CODE_MAGENTA};

	int unsigned set_w [0:9] = '{128, 128, 1, 4096, 0, 300, 8191, 4096, 640, 481};
	int unsigned set_h [0:9] = '{128, 128, 1, 4096, 300, 0, 4096, 1, 480, 640};
	logic [MODE_W-1:0] set_mode [0:9] = '{MODE_FLOW, MODE_GRAY, MODE_COLOUR,
		MODE_FLOW, MODE_COLOUR, MODE_GRAY, MODE_SPARE, MODE_GRAY, MODE_COLOUR,
		MODE_FLOW};

	frame_to_rgb565_scaler uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.byte_address (byte_address),
		.byte_value   (byte_value),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.done         (done),
		.pixel_rgb565 (pixel_rgb565)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [PIX_W-1:0] to_rgb565(input logic [7:0] r,
		input logic [7:0] g, input logic [7:0] b);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

	function automatic logic [7:0] sat_byte(input int a);
		if (a < 0)
			return 8'd0;
		if (a > 255)
			return 8'd255;
		return a[7:0];
	endfunction

	function automatic int unsigned source_index(input int unsigned ofs,
		input int unsigned inv);
		longint unsigned idx;
		idx = (longint'(ofs) * longint'(inv)) >> 16;
		if (idx > SIDE - 1)
			idx = SIDE - 1;
		return int'(idx);
	endfunction

	function automatic logic [PIX_W-1:0] predict_pixel(input logic [COORD_W-1:0] px,
		input logic [COORD_W-1:0] py);
		int unsigned ux, uy, w, h, side, x0, y0, inv, sx, sy, base;
		int u, v, yy;
		logic [7:0] lum;
		ux = px;
		uy = py;
		w = disp_w;
		h = disp_h;
		if (ux >= w || uy >= h)
			return PIX_BLACK;
		side = (w < h) ? w : h;
		if (side == 0)
			return PIX_BLACK;
		x0 = (w - side) / 2;
		y0 = (h - side) / 2;
		if (ux < x0 || ux >= x0 + side || uy < y0 || uy >= y0 + side)
			return PIX_BLACK;
		inv = (SIDE << 16) / side;
		sx = source_index(ux - x0, inv);
		sy = source_index(uy - y0, inv);
		lum = luma_img[sy * SIDE + sx];
		case (col_mode)
			MODE_GRAY: begin
				return to_rgb565(lum, lum, lum);
			end
			MODE_FLOW: begin
				case (lum)
					FLOW_CODE_BLACK:   return PIX_BLACK;
					FLOW_CODE_RED:     return PIX_RED;
					FLOW_CODE_CYAN:    return PIX_CYAN;
					FLOW_CODE_GREEN:   return PIX_GREEN;
					FLOW_CODE_MAGENTA: return PIX_MAGENTA;
					default:           return to_rgb565(lum, lum, lum);
				endcase
			end
			default: begin
				// chroma pair shared by the even/odd column pair, half rows
				base = (sy >> 1) * SIDE + (sx & ~32'd1);
				yy = lum;
				u = int'(chroma_img[base]) - 128;
				v = int'(chroma_img[base + 1]) - 128;
				return to_rgb565(sat_byte(yy + ((int'(COEF_RV) * v) >>> 8)),
					sat_byte(yy - ((int'(COEF_GU) * u + int'(COEF_GV) * v) >>> 8)),
					sat_byte(yy + ((int'(COEF_BU) * u) >>> 8)));
			end
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] pick_byte();
		if ($urandom_range(0, 3) == 0)
			return flow_codes[$urandom_range(0, 4)];
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	// mostly inside the display or just past its edge
	function automatic logic [COORD_W-1:0] pick_coord(input int unsigned extent);
		int unsigned hi;
		if (extent == 0 || $urandom_range(0, 9) < 3)
			return COORD_W'($urandom_range(0, 4095));
		hi = (extent >= 4095) ? 4095 : extent;
		return COORD_W'($urandom_range(0, hi));
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $realtime, what);
		n_errors++;
	endtask

	task automatic push_write(input int unsigned addr, input logic [BYTE_W-1:0] value);
		frame_cmd_t c;
		c.kind = REQ_WRITE;
		c.addr = ADDR_W'(addr);
		c.value = value;
		c.px = COORD_W'($urandom_range(0, 4095));
		c.py = COORD_W'($urandom_range(0, 4095));
		if (addr < LUMA_BYTES)
			luma_set[addr] = 1'b1;
		else if (addr < LUMA_BYTES + CHROMA_BYTES)
			chroma_set[addr - LUMA_BYTES] = 1'b1;
		frame_cmds.push_back(c);
		n_pushed++;
	endtask

	// source bytes the read lands on are written first if still unset
	task automatic push_read(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
		frame_cmd_t c;
		int unsigned w, h, side, x0, y0, inv, sx, sy, base;
		w = disp_w;
		h = disp_h;
		side = (w < h) ? w : h;
		if (px < w && py < h && side != 0) begin
			x0 = (w - side) / 2;
			y0 = (h - side) / 2;
			if (px >= x0 && px < x0 + side && py >= y0 && py < y0 + side) begin
				inv = (SIDE << 16) / side;
				sx = source_index(px - x0, inv);
				sy = source_index(py - y0, inv);
				base = (sy >> 1) * SIDE + (sx & ~32'd1);
				if (!luma_set[sy * SIDE + sx])
					push_write(sy * SIDE + sx, pick_byte());
				if (!chroma_set[base])
					push_write(LUMA_BYTES + base, pick_byte());
				if (!chroma_set[base + 1])
					push_write(LUMA_BYTES + base + 1, pick_byte());
			end
		end
		c.kind = REQ_READ;
		c.addr = ADDR_W'($urandom_range(0, 32767));
		c.value = BYTE_W'($urandom_range(0, 255));
		c.px = px;
		c.py = py;
		frame_cmds.push_back(c);
		n_pushed++;
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_WIDTH:  disp_w = val;
			REG_HEIGHT: disp_h = val;
			REG_MODE:   col_mode = val[MODE_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic settle();
		@(negedge clk);
		while (frame_cmds.size() != 0 || start || pending_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				if (cur.kind == REQ_WRITE) begin
					if (cur.addr < LUMA_BYTES)
						luma_img[cur.addr] = cur.value;
					else if (cur.addr < LUMA_BYTES + CHROMA_BYTES)
						chroma_img[cur.addr - LUMA_BYTES] = cur.value;
					else
						n_ignored++;
					n_writes++;
				end else begin
					want.pix = predict_pixel(cur.px, cur.py);
					want.px = cur.px;
					want.py = cur.py;
					pending_pixels.push_back(want);
					n_reads++;
				end
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (frame_cmds.size() > 0) begin
					cur = frame_cmds.pop_front();
					start <= 1'b1;
					req_type <= cur.kind;
					byte_address <= cur.addr;
					byte_value <= cur.value;
					pixel_x <= cur.px;
					pixel_y <= cur.py;
					if (burst_left > 0) begin
						burst_left--;
						gap_left = 0;
					end else begin
						roll = $urandom_range(0, 99);
						if (roll < 2)
							burst_left = $urandom_range(20, 80);
						if (roll < 55)
							gap_left = 0;
						else if (roll < 85)
							gap_left = $urandom_range(1, 3);
						else if (roll < 97)
							gap_left = $urandom_range(4, 12);
						else
							gap_left = $urandom_range(20, 60);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch($sformatf("result %h with no read outstanding", pixel_rgb565));
			end else begin
				seen = pending_pixels.pop_front();
				n_checked++;
				if (pixel_rgb565 !== seen.pix)
					report_mismatch($sformatf("pixel (%0d,%0d): got %h, want %h",
						seen.px, seen.py, pixel_rgb565, seen.pix));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no item or result for %0d cycles", IDLE_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int unsigned w, h, n;
		logic [MODE_W-1:0] m;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: saturation both ways, ignored addresses, off-display reads
		push_write(0, 8'd255);
		push_write(LUMA_BYTES, 8'd255);
		push_write(LUMA_BYTES + 1, 8'd255);
		push_read(0, 0);
		push_write(LUMA_BYTES - 1, 8'd0);
		push_write(LUMA_BYTES + CHROMA_BYTES - 2, 8'd0);
		push_write(LUMA_BYTES + CHROMA_BYTES - 1, 8'd0);
		push_read(127, 127);
		push_write(LUMA_BYTES + CHROMA_BYTES, 8'h5a);
		push_write(32767, 8'ha5);
		push_read(127, 127);
		push_read(128, 0);
		push_read(0, 128);
		push_read(4095, 4095);
		push_write(LUMA_BYTES, 8'd0);
		push_write(LUMA_BYTES + 1, 8'd255);
		push_write(0, 8'd128);
		push_read(0, 0);
		settle();

		for (int ph = 0; ph < 14; ph++) begin
			if (ph < 10) begin
				w = set_w[ph];
				h = set_h[ph];
				m = set_mode[ph];
			end else begin
				w = $urandom_range(1, 4096);
				h = $urandom_range(1, 4096);
				m = MODE_W'($urandom_range(0, 3));
			end
			write_reg(REG_WIDTH, DIM_W'(w));
			write_reg(REG_HEIGHT, DIM_W'(h));
			write_reg(REG_MODE, DIM_W'(m));
			n_settings++;
			@(negedge clk);
			n = n_pushed;
			while (n_pushed - n < PHASE_ITEMS) begin
				roll = $urandom_range(0, 99);
				if (roll < 3)
					push_write($urandom_range(LUMA_BYTES + CHROMA_BYTES, 32767),
						BYTE_W'($urandom_range(0, 255)));
				else if (roll < 30)
					push_write($urandom_range(0, LUMA_BYTES + CHROMA_BYTES - 1),
						pick_byte());
				else
					push_read(pick_coord(disp_w), pick_coord(disp_h));
			end
			settle();
		end

		if (pending_pixels.size() != 0)
			report_mismatch($sformatf("%0d reads never answered", pending_pixels.size()));

		$display("Covered %0d byte writes (%0d past the chroma plane) and %0d pixel reads",
			n_writes, n_ignored, n_reads);
		$display("over %0d display settings; %0d results checked, %0d mismatches",
			n_settings, n_checked, n_errors);
		if (n_errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/frs_pkg.sv
rtl/frs_ram.sv
rtl/frs_cfg.sv
rtl/frs_conv.sv
rtl/frame_to_rgb565_scaler.sv
rtl/frs_checker.sv
dv/frame_to_rgb565_scaler_tb.sv
